/* rtl/core/fhv_pkg.sv */
// Shared types and constants for the frame header validator.
package fhv_pkg;

  localparam int unsigned HDR_BYTES = 32;
  localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);
  localparam int unsigned HDR_BITS  = HDR_BYTES * 8;
  localparam int unsigned CNT_W     = 33;

  // Byte offsets of the header fields
  localparam int unsigned MAGIC_OFS = 0;
  localparam int unsigned VER_OFS   = 4;
  localparam int unsigned KIND_OFS  = 6;
  localparam int unsigned SEQ_OFS   = 8;
  localparam int unsigned TS_OFS    = 16;
  localparam int unsigned PLEN_OFS  = 24;
  localparam int unsigned FLAGS_OFS = 28;

  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [0:0] {
    CFG_MAGIC   = 1'b0,
    CFG_VERSION = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_LENGTH   = 3'd4,
    ST_SEQUENCE = 3'd5
  } status_e;

  // One finished frame, handed from the front to the back
  typedef struct packed {
    logic             short_frame;
    logic [CNT_W-1:0] total;
    logic [63:0]      prev;
    logic [31:0]      magic;
    logic [15:0]      version;
    logic [15:0]      kind;
    logic [63:0]      seq;
    logic [63:0]      ts;
    logic [31:0]      plen;
    logic [31:0]      flags;
  } hdr_rec_t;

endpackage

/* rtl/core/fhv_front.sv */
// Byte intake: counts bytes, captures the header and emits one record per frame.
module fhv_front import fhv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_frame_i,
  input  logic [63:0] prev_sequence_i,
  output logic        push_o,
  output hdr_rec_t    rec_o
);

  logic [CNT_W-1:0]     count_q, count_d;
  logic [63:0]          prev_q, prev_d;
  logic [7:0]           header_store_q [HDR_BYTES];
  logic [HDR_IDX_W-1:0] idx;
  logic                 in_hdr;
  logic [CNT_W-1:0]     total;
  logic [HDR_BITS-1:0]  flat;

  assign idx    = count_q[HDR_IDX_W-1:0];
  assign in_hdr = (count_q[CNT_W-1:HDR_IDX_W] == '0);
  assign total  = (count_q == {CNT_W{1'b1}}) ? count_q : count_q + CNT_W'(1);

  always_comb begin
    prev_d  = prev_q;
    count_d = count_q;
    if (acc_i) begin
      if (count_q == '0) prev_d = prev_sequence_i;
      count_d = end_of_frame_i ? '0 : total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      prev_q  <= '0;
    end else begin
      count_q <= count_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && in_hdr) header_store_q[idx] <= data_byte_i;
  end

  // Header as seen after this byte lands in the store
  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      flat[8*i +: 8] = (in_hdr && idx == HDR_IDX_W'(i)) ? data_byte_i : header_store_q[i];
    end
  end

  assign push_o = acc_i && end_of_frame_i;

  always_comb begin
    rec_o.short_frame = (total[CNT_W-1:HDR_IDX_W] == '0);
    rec_o.total       = total;
    rec_o.prev        = (count_q == '0) ? prev_sequence_i : prev_q;
    rec_o.magic       = flat[MAGIC_OFS*8 +: 32];
    rec_o.version     = flat[VER_OFS*8   +: 16];
    rec_o.kind        = flat[KIND_OFS*8  +: 16];
    rec_o.seq         = flat[SEQ_OFS*8   +: 64];
    rec_o.ts          = flat[TS_OFS*8    +: 64];
    rec_o.plen        = flat[PLEN_OFS*8  +: 32];
    rec_o.flags       = flat[FLAGS_OFS*8 +: 32];
  end

endmodule

/* rtl/core/fhv_fifo.sv */
// Two-entry record queue between the front and the back.
module fhv_fifo import fhv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hdr_rec_t rec_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output hdr_rec_t rec_o
);

  hdr_rec_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign rec_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= rec_i;
  end

endmodule

/* rtl/core/fhv_back.sv */
// Header checks, configuration registers and the result register.
module fhv_back import fhv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  cfg_reg_e              cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  rec_valid_i,
  input  hdr_rec_t              rec_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  frame_ok_o,
  output status_e               status_o,
  output logic [15:0]           kind_o,
  output logic [63:0]           sequence_res_o,
  output logic [63:0]           timestamp_o,
  output logic [31:0]           payload_length_o,
  output logic [31:0]           flag_bits_o
);

  logic [31:0]      magic_q;
  logic [15:0]      version_q;
  logic             out_valid_q, out_valid_d;
  logic             take;
  status_e          status_d, status_q;
  logic [CNT_W-1:0] claimed;
  hdr_rec_t         res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      version_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAGIC:   magic_q   <= cfg_data_i;
        CFG_VERSION: version_q <= cfg_data_i[15:0];
        default:     ;
      endcase
    end
  end

  assign take    = rec_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o   = take;
  assign claimed = {1'b0, rec_i.plen} + CNT_W'(HDR_BYTES);

  always_comb begin
    priority if (rec_i.short_frame)           status_d = ST_SHORT;
    else if (rec_i.magic != magic_q)          status_d = ST_MAGIC;
    else if (rec_i.version != version_q)      status_d = ST_VERSION;
    else if (claimed != rec_i.total)          status_d = ST_LENGTH;
    else if (!(rec_i.seq > rec_i.prev))       status_d = ST_SEQUENCE;
    else                                      status_d = ST_OK;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take)              out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  // Zero the decoded fields of a short frame
  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      res_q    <= rec_i.short_frame ? '0 : rec_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_ok_o       = (status_q == ST_OK);
  assign status_o         = status_q;
  assign kind_o           = res_q.kind;
  assign sequence_res_o   = res_q.seq;
  assign timestamp_o      = res_q.ts;
  assign payload_length_o = res_q.plen;
  assign flag_bits_o      = res_q.flags;

endmodule

/* rtl/core/frame_header_validator.sv */
// Top level of the frame header validator: byte intake, record queue and checker.
// Takes one byte per cycle; in_stall_o rises only while both queue entries are held.
// The last byte queues the frame record; the checker takes it into the result register.
// Rates: one byte per cycle unless in_stall_o, one result per cycle unless out_stall_i.
// Asynchronous active-low reset clears the byte count, saved sequence, config and valids;
// the header store has no reset; a short frame reads stale bytes, zeroed in the result.
module frame_header_validator import fhv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_frame_i,
  input  logic [63:0]           prev_sequence_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  frame_ok_o,
  output logic [2:0]            status_o,
  output logic [15:0]           kind_o,
  output logic [63:0]           sequence_res_o,
  output logic [63:0]           timestamp_o,
  output logic [31:0]           payload_length_o,
  output logic [31:0]           flag_bits_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic     acc;
  logic     push;
  logic     full;
  logic     rec_valid;
  logic     pop;
  hdr_rec_t front_rec;
  hdr_rec_t queue_rec;
  status_e  status;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;
  assign status_o   = status;

  fhv_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .acc_i           (acc),
    .data_byte_i     (data_byte_i),
    .end_of_frame_i  (end_of_frame_i),
    .prev_sequence_i (prev_sequence_i),
    .push_o          (push),
    .rec_o           (front_rec)
  );

  fhv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .full_o  (full),
    .valid_o (rec_valid),
    .pop_i   (pop),
    .rec_o   (queue_rec)
  );

  fhv_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_reg_e'(cfg_idx_i)),
    .cfg_data_i       (cfg_data_i),
    .rec_valid_i      (rec_valid),
    .rec_i            (queue_rec),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_ok_o       (frame_ok_o),
    .status_o         (status),
    .kind_o           (kind_o),
    .sequence_res_o   (sequence_res_o),
    .timestamp_o      (timestamp_o),
    .payload_length_o (payload_length_o),
    .flag_bits_o      (flag_bits_o)
  );

`ifndef SYNTHESIS
  a_ok_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_ok_o == (status == ST_OK)))
    else $error("frame_ok disagrees with status");

  a_short_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status == ST_SHORT) |->
      (kind_o == '0 && sequence_res_o == '0 && timestamp_o == '0 &&
       payload_length_o == '0 && flag_bits_o == '0))
    else $error("short frame carries nonzero header fields");

  a_no_result_from_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !rec_valid) |=> !out_valid_o)
    else $error("result appeared with an empty queue");
`endif

endmodule
